@@ rtl/core/sot_pkg.sv @@
// Types and constants shared by the segment offset translator and its checker.
package sot_pkg;

    localparam int POS_BITS  = 32;
    localparam int SEG_W     = 10;
    localparam int CNT_OUT_W = 11;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_TO_ABS = 2'd1,
        REQ_TO_SEG = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req_kind;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NO_SEG   = 3'd1,
        STAT_OFF_PAST = 3'd2,
        STAT_PAST_END = 3'd3,
        STAT_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_R1_END,
        S_R1_START,
        S_SEARCH,
        S_R2_START
    } t_state;

    typedef struct packed {
        t_req_kind           req_type;
        logic [POS_BITS-1:0] seg_length;
        logic [SEG_W-1:0]    seg_number;
        logic [POS_BITS-1:0] seg_offset;
        logic [POS_BITS-1:0] abs_position;
    } t_req;

    typedef struct packed {
        logic [SEG_W-1:0]     out_segment;
        logic [POS_BITS-1:0]  out_offset;
        logic [POS_BITS-1:0]  out_absolute;
        logic [POS_BITS-1:0]  reference_total;
        logic [CNT_OUT_W-1:0] segment_count;
        t_status              status;
    } t_rsp;

endpackage

@@ rtl/core/segment_offset_translator_unit.sv @@
// Segment offset translator: running-end table with append and two lookups.
// Append, reserved and out-of-range lookup requests finish in the decode state; segment+offset
// to absolute reads the segment's end, then its start; absolute to segment runs a binary
// search with one table read per step, then reads the start of the segment found.
// One request at a time; busy is high until the result is issued.
// Synchronous active-low reset empties the table at once; results cannot be stalled.
module segment_offset_translator_unit
    import sot_pkg::*;
#(
    parameter int MAX_SEGMENTS = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int EXT_W = CNT_W + CNT_OUT_W;

    logic [POS_BITS-1:0] r_running_end [MAX_SEGMENTS];

    t_state              r_state, n_state;
    t_req                r_req;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [POS_BITS-1:0] r_total, n_total;
    logic [IDX_W-1:0]    r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [POS_BITS-1:0] r_end, n_end;
    logic [POS_BITS-1:0] r_rd_data;
    logic                r_done, n_done;
    t_rsp                r_rsp, n_rsp;

    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [POS_BITS-1:0] wr_data;

    logic [POS_BITS-1:0] alu_a, alu_b;
    logic                alu_sub;
    logic [POS_BITS:0]   alu_y;

    logic                accept;
    logic                full, no_seg, past_end, seg_zero, lo_zero;
    logic [EXT_W-1:0]    seg_ext, cnt_ext, lo_ext;
    logic [IDX_W-1:0]    seg_idx, cnt_m1;
    logic [CNT_W-1:0]    cnt_dec;
    logic                go_low, search_end;
    logic [IDX_W-1:0]    s_lo, s_hi, s_mid;
    logic [POS_BITS-1:0] start_pos;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // shared add/subtract unit
    assign alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

    assign seg_ext  = EXT_W'(r_req.seg_number);
    assign cnt_ext  = EXT_W'(r_count);
    assign lo_ext   = EXT_W'(r_lo);
    assign seg_idx  = seg_ext[IDX_W-1:0];
    assign cnt_dec  = r_count - CNT_W'(1);
    assign cnt_m1   = cnt_dec[IDX_W-1:0];
    assign full     = (r_count == CNT_W'(MAX_SEGMENTS));
    assign no_seg   = (seg_ext >= cnt_ext);
    assign past_end = (r_count == '0) || (r_req.abs_position > r_total);
    assign seg_zero = (r_req.seg_number == '0);
    assign lo_zero  = (r_lo == '0);

    // one binary search step on the entry read at r_mid
    assign go_low     = (r_rd_data >= r_req.abs_position);
    assign s_lo       = go_low ? r_lo : (r_mid + IDX_W'(1));
    assign s_hi       = go_low ? r_mid : r_hi;
    assign s_mid      = s_lo + ((s_hi - s_lo) >> 1);
    assign search_end = (s_lo == s_hi);

    assign start_pos = (((r_state == S_R1_START) && seg_zero) ||
                        ((r_state == S_R2_START) && lo_zero)) ? '0 : r_rd_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_req.req_type)
                    REQ_TO_ABS: n_state = no_seg ? S_IDLE : S_R1_END;
                    REQ_TO_SEG: begin
                        if (past_end) begin
                            n_state = S_IDLE;
                        end else if (cnt_m1 == '0) begin
                            n_state = S_R2_START;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_R1_END:   n_state = S_R1_START;
            S_SEARCH:   n_state = search_end ? S_R2_START : S_SEARCH;
            S_R1_START: n_state = S_IDLE;
            S_R2_START: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        t_rsp res;
        res       = '0;
        n_count   = r_count;
        n_total   = r_total;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_end     = r_end;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        rd_addr   = r_mid;
        wr_en     = 1'b0;
        wr_addr   = r_count[IDX_W-1:0];
        wr_data   = alu_y[POS_BITS-1:0];
        alu_a     = r_total;
        alu_b     = r_req.seg_length;
        alu_sub   = 1'b0;
        res.status = STAT_OK;
        unique case (r_state)
            S_IDLE: ;
            S_DECODE: begin
                unique case (r_req.req_type)
                    REQ_APPEND: begin
                        n_done = 1'b1;
                        if (full || alu_y[POS_BITS]) begin
                            res.status = STAT_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_total = alu_y[POS_BITS-1:0];
                        end
                    end
                    REQ_TO_ABS: begin
                        rd_addr = seg_idx;
                        if (no_seg) begin
                            n_done          = 1'b1;
                            res.out_segment = r_req.seg_number;
                            res.status      = STAT_NO_SEG;
                        end
                    end
                    REQ_TO_SEG: begin
                        n_lo  = '0;
                        n_hi  = cnt_m1;
                        n_mid = cnt_m1 >> 1;
                        rd_addr = cnt_m1 >> 1;
                        if (past_end) begin
                            n_done     = 1'b1;
                            res.status = STAT_PAST_END;
                        end
                    end
                    default: n_done = 1'b1;
                endcase
            end
            S_R1_END: begin
                n_end   = r_rd_data;
                rd_addr = seg_idx - IDX_W'(1);
            end
            S_R1_START: begin
                alu_a           = start_pos;
                alu_b           = r_req.seg_offset;
                n_done          = 1'b1;
                res.out_segment = r_req.seg_number;
                if (alu_y > {1'b0, r_end}) begin
                    res.status = STAT_OFF_PAST;
                end else begin
                    res.out_absolute = alu_y[POS_BITS-1:0];
                end
            end
            S_SEARCH: begin
                n_lo  = s_lo;
                n_hi  = s_hi;
                n_mid = s_mid;
                rd_addr = search_end ? (s_lo - IDX_W'(1)) : s_mid;
            end
            S_R2_START: begin
                alu_a           = r_req.abs_position;
                alu_b           = start_pos;
                alu_sub         = 1'b1;
                n_done          = 1'b1;
                res.out_segment = lo_ext[SEG_W-1:0];
                res.out_offset  = alu_y[POS_BITS-1:0];
            end
            default: ;
        endcase
        if (n_done) begin
            res.reference_total = n_total;
            res.segment_count   = CNT_OUT_W'(n_count);
            n_rsp = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_end <= n_end;
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_running_end[wr_addr] <= wr_data;
        end
        r_rd_data <= r_running_end[rd_addr];
    end

endmodule

@@ rtl/core/sot_checker.sv @@
// Port-level checker for the segment offset translator, bound to the top level.
module sot_checker
    import sot_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp
);

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_rst_n) |=> busy)
        else $error("busy not raised after an accepted request");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != STAT_OK)) |->
            (o_rsp.out_offset == '0) && (o_rsp.out_absolute == '0))
        else $error("error result carries position data");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_rsp.status == STAT_OK) || (o_rsp.status == STAT_NO_SEG) ||
                    (o_rsp.status == STAT_OFF_PAST) || (o_rsp.status == STAT_PAST_END) ||
                    (o_rsp.status == STAT_FULL)))
        else $error("undefined status code on result");

endmodule

bind segment_offset_translator_unit sot_checker u_sot_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

@@ dv/segment_offset_translator_unit_tb.sv @@
// Self-checking testbench for the segment offset translator: directed table, then random requests.
module segment_offset_translator_unit_tb;
    import sot_pkg::*;

    localparam int MAX_SEGS     = 1024;
    localparam int N_RANDOM     = 1850;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS   = 200;
    localparam int IDLE_PLAN [4] = '{0, 85, 0, 11};

    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    logic [31:0] seg_end [MAX_SEGS];
    int          seg_cnt   = 0;
    logic [31:0] seg_total = '0;
    t_rsp        pending_rsp [$];
    int          errors    = 0;

    segment_offset_translator_unit #(.MAX_SEGMENTS(MAX_SEGS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] seg_base(int k);
        return (k == 0) ? '0 : seg_end[k - 1];
    endfunction

    // Updates the shadow table and returns the result the request should give.
    function automatic t_rsp expected_translation(t_req r);
        t_rsp        rsp;
        logic [32:0] sum;
        logic [31:0] base;
        int          lo;
        int          hi;
        int          mid;
        rsp = '0;
        rsp.status = STAT_OK;
        case (r.req_type)
            REQ_APPEND: begin
                sum = {1'b0, seg_total} + {1'b0, r.seg_length};
                if (seg_cnt >= MAX_SEGS || sum[32]) begin
                    rsp.status = STAT_FULL;
                end else begin
                    seg_end[seg_cnt] = sum[31:0];
                    seg_cnt++;
                    seg_total = sum[31:0];
                end
            end
            REQ_TO_ABS: begin
                rsp.out_segment = r.seg_number;
                if (int'(r.seg_number) >= seg_cnt) begin
                    rsp.status = STAT_NO_SEG;
                end else begin
                    base = seg_base(r.seg_number);
                    if (r.seg_offset > seg_end[r.seg_number] - base)
                        rsp.status = STAT_OFF_PAST;
                    else
                        rsp.out_absolute = base + r.seg_offset;
                end
            end
            REQ_TO_SEG: begin
                if (seg_cnt == 0 || r.abs_position > seg_total) begin
                    rsp.status = STAT_PAST_END;
                end else begin
                    lo = 0;
                    hi = seg_cnt - 1;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (seg_end[mid] >= r.abs_position)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    rsp.out_segment = 10'(lo);
                    rsp.out_offset  = r.abs_position - seg_base(lo);
                end
            end
            default: ;
        endcase
        rsp.reference_total = seg_total;
        rsp.segment_count   = 11'(seg_cnt);
        return rsp;
    endfunction

    // Holds the request until taken, then queues its result and idles at random.
    task automatic issue(input t_req r, input bit fixed, input t_rsp typed, input int idle_pct);
        t_rsp model;
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        model = expected_translation(r);
        pending_rsp.insert(pending_rsp.size(), fixed ? typed : model);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    task automatic report_field(input string fname, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: unexpected result, expected none, got %h", $time, o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.out_segment !== want.out_segment)
                    report_field("out_segment", 32'(want.out_segment),
                                 32'(o_rsp.out_segment));
                if (o_rsp.out_offset !== want.out_offset)
                    report_field("out_offset", want.out_offset, o_rsp.out_offset);
                if (o_rsp.out_absolute !== want.out_absolute)
                    report_field("out_absolute", want.out_absolute, o_rsp.out_absolute);
                if (o_rsp.reference_total !== want.reference_total)
                    report_field("reference_total", want.reference_total,
                                 o_rsp.reference_total);
                if (o_rsp.segment_count !== want.segment_count)
                    report_field("segment_count", 32'(want.segment_count),
                                 32'(o_rsp.segment_count));
                if (o_rsp.status !== want.status)
                    report_field("status", 32'(want.status), 32'(o_rsp.status));
            end
        end
    end

    // Ends the run if neither a request nor a result moves for too long.
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done)
                stall = 0;
            else
                stall++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_row        directed [24];
        t_req        r;
        int          pick;
        int          sel;
        int          k;
        int          app_lim;
        logic [31:0] base;
        logic [31:0] size;

        // Table after the appends below: ends 10, 10, 15 (segment 1 is empty).
        directed = '{
            '{'{REQ_TO_SEG, 0, 0, 0, 0},        1'b1, '{0, 0, 0, 0, 0, STAT_PAST_END}},
            '{'{REQ_TO_ABS, 0, 0, 0, 0},        1'b1, '{0, 0, 0, 0, 0, STAT_NO_SEG}},
            '{'{REQ_TO_ABS, 0, 1023, '1, 0},    1'b1, '{1023, 0, 0, 0, 0, STAT_NO_SEG}},
            '{'{REQ_RSVD, '1, '1, '1, '1},      1'b1, '{0, 0, 0, 0, 0, STAT_OK}},
            '{'{REQ_APPEND, 10, 0, 0, 0},       1'b1, '{0, 0, 0, 10, 1, STAT_OK}},
            '{'{REQ_APPEND, '1, 0, 0, 0},       1'b1, '{0, 0, 0, 10, 1, STAT_FULL}},
            '{'{REQ_APPEND, 0, 0, 0, 0},        1'b1, '{0, 0, 0, 10, 2, STAT_OK}},
            '{'{REQ_APPEND, 5, 0, 0, 0},        1'b1, '{0, 0, 0, 15, 3, STAT_OK}},
            '{'{REQ_TO_ABS, 0, 0, 0, 0},        1'b1, '{0, 0, 0, 15, 3, STAT_OK}},
            '{'{REQ_TO_ABS, 0, 0, 10, 0},       1'b1, '{0, 0, 10, 15, 3, STAT_OK}},
            '{'{REQ_TO_ABS, 0, 0, 11, 0},       1'b1, '{0, 0, 0, 15, 3, STAT_OFF_PAST}},
            '{'{REQ_TO_ABS, 0, 1, 0, 0},        1'b0, '0},
            '{'{REQ_TO_ABS, 0, 1, 1, 0},        1'b0, '0},
            '{'{REQ_TO_ABS, 0, 2, 5, 0},        1'b0, '0},
            '{'{REQ_TO_ABS, 0, 3, 0, 0},        1'b1, '{3, 0, 0, 15, 3, STAT_NO_SEG}},
            '{'{REQ_TO_ABS, 0, 0, '1, 0},       1'b1, '{0, 0, 0, 15, 3, STAT_OFF_PAST}},
            '{'{REQ_TO_SEG, 0, 0, 0, 0},        1'b1, '{0, 0, 0, 15, 3, STAT_OK}},
            '{'{REQ_TO_SEG, 0, 0, 0, 10},       1'b0, '0},
            '{'{REQ_TO_SEG, 0, 0, 0, 11},       1'b0, '0},
            '{'{REQ_TO_SEG, 0, 0, 0, 15},       1'b0, '0},
            '{'{REQ_TO_SEG, 0, 0, 0, 16},       1'b1, '{0, 0, 0, 15, 3, STAT_PAST_END}},
            '{'{REQ_TO_SEG, 0, 0, 0, '1},       1'b1, '{0, 0, 0, 15, 3, STAT_PAST_END}},
            '{'{REQ_APPEND, 32'hFFFF_FFF1, 0, 0, 0},
                                                1'b1, '{0, 0, 0, 15, 3, STAT_FULL}},
            '{'{REQ_RSVD, 32'h5A5A_5A5A, 10'h2A5, 32'hA5A5_A5A5, 32'h0F0F_0F0F},
                                                1'b1, '{0, 0, 0, 15, 3, STAT_OK}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            issue(directed[i].req, directed[i].fixed, directed[i].rsp, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            r.seg_length   = $urandom();
            r.seg_number   = 10'($urandom());
            r.seg_offset   = $urandom();
            r.abs_position = $urandom();
            pick    = $urandom_range(0, 99);
            sel     = $urandom_range(0, 99);
            app_lim = (seg_cnt < MAX_SEGS) ? 65 : 8;
            if (pick < app_lim) begin
                r.req_type = REQ_APPEND;
                // once the sum is at its ceiling only empty segments still fit
                if (seg_total == '1) begin
                    if (sel < 60)
                        r.seg_length = '0;
                end else if (sel < 4 && seg_total != 0) begin
                    r.seg_length = ~seg_total + 32'd1 + $urandom_range(0, seg_total - 1);
                end else if (seg_cnt >= 1000 && sel < 14) begin
                    r.seg_length = ~seg_total;
                end else if (sel < 20) begin
                    r.seg_length = '0;
                end else if (sel < 45) begin
                    r.seg_length = $urandom_range(1, 8);
                end else if (sel < 80) begin
                    r.seg_length = $urandom_range(1, 1000);
                end else begin
                    r.seg_length = $urandom_range(1, 1 << 22);
                end
            end else if (pick < app_lim + (96 - app_lim) / 2) begin
                r.req_type = REQ_TO_ABS;
                if (seg_cnt != 0 && sel < 70) begin
                    k = $urandom_range(0, seg_cnt - 1);
                    r.seg_number = 10'(k);
                    base = seg_base(k);
                    size = seg_end[k] - base;
                    if (sel < 35)
                        r.seg_offset = $urandom_range(0, size);
                    else if (sel < 45)
                        r.seg_offset = size;
                    else if (sel < 52)
                        r.seg_offset = '0;
                    else if (sel < 60)
                        r.seg_offset = size + 32'd1;
                end
            end else if (pick < 96) begin
                r.req_type = REQ_TO_SEG;
                if (seg_cnt != 0 && sel < 90) begin
                    k = $urandom_range(0, seg_cnt - 1);
                    if (sel < 50)
                        r.abs_position = $urandom_range(0, seg_total);
                    else if (sel < 65)
                        r.abs_position = seg_end[k];
                    else if (sel < 80)
                        r.abs_position = seg_end[k] + 32'd1;
                    else
                        r.abs_position = seg_total + 32'd1;
                end
            end else begin
                r.req_type = REQ_RSVD;
            end
            issue(r, 1'b0, '0, IDLE_PLAN[n * 4 / N_RANDOM]);
        end

        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ segment_offset_translator_unit.f @@
rtl/core/sot_pkg.sv
rtl/core/segment_offset_translator_unit.sv
rtl/core/sot_checker.sv
dv/segment_offset_translator_unit_tb.sv
